// ===== rtl/lav_pkg.sv =====
package lav_pkg;

    // Coordinate width of every input field and every result column
    localparam int XW = 32;

    // Row codes of the result channel
    localparam logic [1:0] ROW_SIDE  = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_GAZE  = 2'd2;
    localparam logic [1:0] ROW_CONST = 2'd3;

    // Saturation limits of a result column
    localparam logic signed [XW-1:0] XMAX = 32'sh7fff_ffff;
    localparam logic signed [XW-1:0] XMIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [XW-1:0] eye_x;
        logic signed [XW-1:0] eye_y;
        logic signed [XW-1:0] eye_z;
        logic signed [XW-1:0] target_x;
        logic signed [XW-1:0] target_y;
        logic signed [XW-1:0] target_z;
        logic signed [XW-1:0] up_x;
        logic signed [XW-1:0] up_y;
        logic signed [XW-1:0] up_z;
    } t_lav_in;

    typedef struct packed {
        logic [1:0]           row_index;
        logic signed [XW-1:0] col0;
        logic signed [XW-1:0] col1;
        logic signed [XW-1:0] col2;
        logic signed [XW-1:0] col3;
        logic                 last_row;
    } t_lav_out;

endpackage

// ===== rtl/lav_if.sv =====
// Input item channel
interface lav_in_if;
    import lav_pkg::*;

    logic    valid;
    logic    ready;
    t_lav_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Result row channel
interface lav_out_if;
    import lav_pkg::*;

    logic     valid;
    logic     ready;
    t_lav_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/look_at_view_matrix_unit.sv =====
// Look-at view matrix, left handed, signed fixed point with FRAC_BITS fraction bits.
// i_item carries eye, target and up points; an item is taken when valid and
// ready are both high. o_row returns four rows per item in order: side axis,
// up axis, gaze axis (each with minus its dot product with eye in col3) and
// the constant row 0,0,0,1, which has last_row set.
// Row 0 is presented once the item has passed the input stage, both normalizers,
// the cross product and eye offset stages and the row buffer; rows 1 to 3 follow
// one per cycle while o_row.ready is high. The pipeline takes a new item every
// cycle unless frozen, but the single result channel moves one row per cycle, so
// four rows per item bound the sustained rate. Depth comes from two normalizers,
// each a one-bit-per-stage square root followed by a one-bit-per-stage divide.
// Reset clears all valid bits and the row counter; no rows are pending after it.
// When the receiver stalls, the current row holds; once the final pipeline stage
// holds an item that cannot move into the row buffer the whole pipeline
// freezes and i_item.ready drops, with nothing lost or repeated.
module look_at_view_matrix_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lav_in_if.sink   i_item,
    lav_out_if.source o_row
);
    import lav_pkg::*;

    localparam int OW   = FRAC_BITS + 2;     // normalized axis
    localparam int UW   = OW + 1;            // up axis
    localparam int PW1  = XW + OW;           // up times gaze
    localparam int RAWW = PW1 + 1;           // raw side axis
    localparam int PW2  = 2 * OW;            // gaze times side
    localparam int PW3  = UW + XW;           // axis times eye
    localparam int DOTW = PW3 + 2;
    localparam int NEGW = DOTW + 1;
    localparam int SD1W = 6 * XW;
    localparam int SD2W = 3 * OW + 3 * XW;
    localparam logic signed [XW-1:0] C_ONE = XW'(2 ** FRAC_BITS);

    logic w_en, w_ser_free;

    // input stage
    logic                  r_a_v;
    logic signed [XW:0]    r_a_d [3];
    logic [2:0][XW-1:0]    r_a_eye, r_a_up;

    // first normalizer
    logic                  w_n1_v;
    logic [2:0][OW-1:0]    w_n1_vec;
    logic [SD1W-1:0]       w_n1_side;
    logic [2:0][XW-1:0]    w_n1_eye, w_n1_up;
    logic signed [XW-1:0]  w_upc [3];
    logic signed [OW-1:0]  w_gc  [3];

    // raw side axis
    logic                  r_c1_v, r_c2_v;
    logic signed [PW1-1:0] r_c1_p [6];
    logic signed [RAWW-1:0] r_c2_raw [3];
    logic [2:0][OW-1:0]    r_c1_gaze, r_c2_gaze;
    logic [2:0][XW-1:0]    r_c1_eye, r_c2_eye;

    // second normalizer
    logic                  w_n2_v;
    logic [2:0][OW-1:0]    w_n2_vec;
    logic [SD2W-1:0]       w_n2_side;
    logic [2:0][OW-1:0]    w_n2_gaze;
    logic [2:0][XW-1:0]    w_n2_eye;
    logic signed [OW-1:0]  w_g2 [3];
    logic signed [OW-1:0]  w_s2 [3];

    // up axis
    logic                  r_e1_v, r_e2_v;
    logic signed [PW2-1:0] r_e1_p [6];
    logic signed [UW-1:0]  r_e2_up [3];
    logic [2:0][OW-1:0]    r_e1_side, r_e1_gaze, r_e2_side, r_e2_gaze;
    logic [2:0][XW-1:0]    r_e1_eye, r_e2_eye;

    // eye offsets
    logic signed [UW-1:0]   w_ax [3][3];
    logic signed [XW-1:0]   w_eyec [3];
    logic                   r_f1_v, r_f2_v, r_f3_v;
    logic signed [PW3-1:0]  r_f1_p [3][3];
    logic signed [DOTW-1:0] r_f2_sh [3];
    logic signed [NEGW-1:0] w_neg [3];
    logic signed [XW-1:0]   n_f3_c3 [3];
    logic signed [XW-1:0]   r_f3_c3 [3];
    logic signed [UW-1:0]   r_f1_ax [3][3];
    logic signed [UW-1:0]   r_f2_ax [3][3];
    logic signed [UW-1:0]   r_f3_ax [3][3];

    // row buffer
    logic                  r_s_v;
    logic [1:0]            r_cnt;
    logic signed [UW-1:0]  r_s_ax [3][3];
    logic signed [XW-1:0]  r_s_c3 [3];

    // flow control: the pipeline moves unless its last item is blocked
    assign w_ser_free   = !r_s_v || (o_row.ready && (r_cnt == ROW_CONST));
    assign w_en         = !r_f3_v || w_ser_free;
    assign i_item.ready = w_en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (w_en) begin
            r_a_v  <= i_item.valid;
            r_c1_v <= w_n1_v;
            r_c2_v <= r_c1_v;
            r_e1_v <= w_n2_v;
            r_e2_v <= r_e1_v;
            r_f1_v <= r_e2_v;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    // gaze difference
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_d[0] <= (XW+1)'(i_item.payload.target_x) - (XW+1)'(i_item.payload.eye_x);
            r_a_d[1] <= (XW+1)'(i_item.payload.target_y) - (XW+1)'(i_item.payload.eye_y);
            r_a_d[2] <= (XW+1)'(i_item.payload.target_z) - (XW+1)'(i_item.payload.eye_z);
            r_a_eye[0] <= i_item.payload.eye_x;
            r_a_eye[1] <= i_item.payload.eye_y;
            r_a_eye[2] <= i_item.payload.eye_z;
            r_a_up[0]  <= i_item.payload.up_x;
            r_a_up[1]  <= i_item.payload.up_y;
            r_a_up[2]  <= i_item.payload.up_z;
        end
    end

    lav_norm #(
        .IN_W      (XW + 1),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SD1W)
    ) u_norm_gaze (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_v),
        .i_vec   ({r_a_d[2], r_a_d[1], r_a_d[0]}),
        .i_side  ({r_a_eye, r_a_up}),
        .o_valid (w_n1_v),
        .o_vec   (w_n1_vec),
        .o_side  (w_n1_side)
    );

    assign w_n1_eye = w_n1_side[SD1W-1:3*XW];
    assign w_n1_up  = w_n1_side[3*XW-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_upc[i] = $signed(w_n1_up[i]);
            w_gc[i]  = $signed(w_n1_vec[i]);
        end
    end

    // up cross gaze: products, then differences
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_p[0]   <= w_upc[1] * w_gc[2];
            r_c1_p[1]   <= w_upc[2] * w_gc[1];
            r_c1_p[2]   <= w_upc[2] * w_gc[0];
            r_c1_p[3]   <= w_upc[0] * w_gc[2];
            r_c1_p[4]   <= w_upc[0] * w_gc[1];
            r_c1_p[5]   <= w_upc[1] * w_gc[0];
            r_c1_gaze   <= w_n1_vec;
            r_c1_eye    <= w_n1_eye;
            r_c2_raw[0] <= RAWW'(r_c1_p[0]) - RAWW'(r_c1_p[1]);
            r_c2_raw[1] <= RAWW'(r_c1_p[2]) - RAWW'(r_c1_p[3]);
            r_c2_raw[2] <= RAWW'(r_c1_p[4]) - RAWW'(r_c1_p[5]);
            r_c2_gaze   <= r_c1_gaze;
            r_c2_eye    <= r_c1_eye;
        end
    end

    lav_norm #(
        .IN_W      (RAWW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SD2W)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c2_v),
        .i_vec   ({r_c2_raw[2], r_c2_raw[1], r_c2_raw[0]}),
        .i_side  ({r_c2_gaze, r_c2_eye}),
        .o_valid (w_n2_v),
        .o_vec   (w_n2_vec),
        .o_side  (w_n2_side)
    );

    assign w_n2_gaze = w_n2_side[SD2W-1:3*XW];
    assign w_n2_eye  = w_n2_side[3*XW-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_g2[i] = $signed(w_n2_gaze[i]);
            w_s2[i] = $signed(w_n2_vec[i]);
        end
    end

    // gaze cross side, scaled back with floor
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_p[0]  <= w_g2[1] * w_s2[2];
            r_e1_p[1]  <= w_g2[2] * w_s2[1];
            r_e1_p[2]  <= w_g2[2] * w_s2[0];
            r_e1_p[3]  <= w_g2[0] * w_s2[2];
            r_e1_p[4]  <= w_g2[0] * w_s2[1];
            r_e1_p[5]  <= w_g2[1] * w_s2[0];
            r_e1_side  <= w_n2_vec;
            r_e1_gaze  <= w_n2_gaze;
            r_e1_eye   <= w_n2_eye;
            r_e2_up[0] <= UW'(((PW2+1)'(r_e1_p[0]) - (PW2+1)'(r_e1_p[1])) >>> FRAC_BITS);
            r_e2_up[1] <= UW'(((PW2+1)'(r_e1_p[2]) - (PW2+1)'(r_e1_p[3])) >>> FRAC_BITS);
            r_e2_up[2] <= UW'(((PW2+1)'(r_e1_p[4]) - (PW2+1)'(r_e1_p[5])) >>> FRAC_BITS);
            r_e2_side  <= r_e1_side;
            r_e2_gaze  <= r_e1_gaze;
            r_e2_eye   <= r_e1_eye;
        end
    end

    // axes in row order
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ax[0][i] = UW'($signed(r_e2_side[i]));
            w_ax[1][i] = r_e2_up[i];
            w_ax[2][i] = UW'($signed(r_e2_gaze[i]));
            w_eyec[i]  = $signed(r_e2_eye[i]);
        end
    end

    // minus axis dot eye, saturated
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_neg[k] = -NEGW'(r_f2_sh[k]);
            if (w_neg[k] > NEGW'(XMAX)) begin
                n_f3_c3[k] = XMAX;
            end else if (w_neg[k] < NEGW'(XMIN)) begin
                n_f3_c3[k] = XMIN;
            end else begin
                n_f3_c3[k] = XW'(w_neg[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_f1_p[k][i] <= w_ax[k][i] * w_eyec[i];
                end
                r_f2_sh[k] <= (DOTW'(r_f1_p[k][0]) + DOTW'(r_f1_p[k][1])
                              + DOTW'(r_f1_p[k][2])) >>> FRAC_BITS;
                r_f3_c3[k] <= n_f3_c3[k];
            end
            r_f1_ax <= w_ax;
            r_f2_ax <= r_f1_ax;
            r_f3_ax <= r_f2_ax;
        end
    end

    // row buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
            r_cnt <= ROW_SIDE;
        end else if (w_ser_free) begin
            r_s_v <= r_f3_v;
            r_cnt <= ROW_SIDE;
        end else if (o_row.ready) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ser_free) begin
            r_s_ax <= r_f3_ax;
            r_s_c3 <= r_f3_c3;
        end
    end

    // row select
    assign o_row.valid = r_s_v;

    always_comb begin
        o_row.payload.row_index = r_cnt;
        o_row.payload.last_row  = (r_cnt == ROW_CONST);
        case (r_cnt) inside
            ROW_SIDE, ROW_UP, ROW_GAZE: begin
                o_row.payload.col0 = XW'(r_s_ax[r_cnt][0]);
                o_row.payload.col1 = XW'(r_s_ax[r_cnt][1]);
                o_row.payload.col2 = XW'(r_s_ax[r_cnt][2]);
                o_row.payload.col3 = r_s_c3[r_cnt];
            end
            default: begin
                o_row.payload.col0 = '0;
                o_row.payload.col1 = '0;
                o_row.payload.col2 = '0;
                o_row.payload.col3 = C_ONE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a taken row that is not the last is followed by the next row of the item
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row.valid && o_row.ready && !o_row.payload.last_row
        |=> o_row.valid
            && (o_row.payload.row_index == 2'($past(o_row.payload.row_index) + 2'd1)))
        else $error("row sequence broken");

    // a blocked final stage holds its item
    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f3_v && !w_en |=> r_f3_v && $stable(r_f3_c3[0]) && $stable(r_f3_c3[2]))
        else $error("final stage item lost while stalled");

    // no new item while rows of the previous one are pending and the tail is full
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v && (r_cnt != ROW_CONST) && r_f3_v |-> !i_item.ready)
        else $error("input taken while pipeline blocked");
`endif

endmodule

// ===== rtl/lav_norm.sv =====
// Pipelined 3-vector normalizer: magnitudes, range shift, squares, bit-per-stage
// square root, bit-per-stage restoring divide, sign restore.
// The pipeline advances only while i_en is high; a zero vector comes out as zero.
module lav_norm #(
    parameter int IN_W      = 33,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [2:0][IN_W-1:0]      i_vec,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [2:0][FRAC_BITS+1:0] o_vec,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int MW  = 30;                    // magnitudes kept below 2^MW
    localparam int OW  = FRAC_BITS + 2;
    localparam int QW  = FRAC_BITS + 1;
    localparam int SQW = 2 * MW + 3;
    localparam int NSQ = MW + 1;
    localparam int DW  = MW + FRAC_BITS + 2;
    localparam int NDV = FRAC_BITS + 1;
    localparam int SHW = $clog2(IN_W - MW + 1);
    localparam int LW  = $clog2(IN_W + 1);

    typedef struct packed {
        logic [SQW-1:0]     num;
        logic [SQW-1:0]     res;
        logic [2:0][MW-1:0] m;
        logic [2:0]         neg;
        logic [SIDE_W-1:0]  side;
    } t_sq;

    typedef struct packed {
        logic [2:0][DW-1:0] rem;
        logic [2:0][QW-1:0] q;
        logic [MW:0]        root;
        logic [2:0]         neg;
        logic [SIDE_W-1:0]  side;
    } t_dv;

    // front stages
    logic                 r0_v, r1_v, r2_v, r3_v;
    logic [2:0][IN_W-1:0] n0_mag, r0_mag, r1_mag;
    logic [2:0]           n0_neg, r0_neg, r1_neg, r2_neg, r3_neg;
    logic [SIDE_W-1:0]    r0_side, r1_side, r2_side, r3_side;
    logic [IN_W-1:0]      w_or;
    logic [LW-1:0]        w_len;
    logic [SHW-1:0]       w_sh, r1_sh;
    logic [2:0][MW-1:0]   n2_m, r2_m, r3_m;
    logic [2:0][2*MW-1:0] n3_sq, r3_sq;

    // root and divide stages
    t_sq  n_sq0;
    t_sq  n_sq  [NSQ];
    t_sq  r_sq  [NSQ+1];
    logic r_sqv [NSQ+1];
    t_dv  n_dv0;
    t_dv  n_dv  [NDV];
    t_dv  r_dv  [NDV+1];
    logic r_dvv [NDV+1];

    logic                 r_o_v;
    logic [2:0][OW-1:0]   n_o_vec, r_o_vec;
    logic [SIDE_W-1:0]    r_o_side;

    // magnitudes and signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n0_neg[i] = i_vec[i][IN_W-1];
            n0_mag[i] = n0_neg[i] ? (~i_vec[i] + IN_W'(1)) : i_vec[i];
        end
    end

    // range shift: bit length of the largest magnitude above MW
    always_comb begin
        w_or  = r0_mag[0] | r0_mag[1] | r0_mag[2];
        w_len = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (w_or[b]) begin
                w_len = LW'(b + 1);
            end
        end
        w_sh = (w_len > LW'(MW)) ? SHW'(w_len - LW'(MW)) : '0;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_m[i]  = MW'(r1_mag[i] >> r1_sh);
            n3_sq[i] = r2_m[i] * r2_m[i];
        end
    end

    // sum of squares enters the root pipeline
    always_comb begin
        n_sq0.num  = SQW'(r3_sq[0]) + SQW'(r3_sq[1]) + SQW'(r3_sq[2]);
        n_sq0.res  = '0;
        n_sq0.m    = r3_m;
        n_sq0.neg  = r3_neg;
        n_sq0.side = r3_side;
    end

    // one root bit per stage, trial bit 4^(MW-g)
    always_comb begin
        logic [SQW-1:0] v_bit;
        logic [SQW-1:0] v_t;
        for (int g = 0; g < NSQ; g++) begin
            n_sq[g] = r_sq[g];
            v_bit   = SQW'(1) << (2 * (MW - g));
            v_t     = r_sq[g].res + v_bit;
            if (r_sq[g].num >= v_t) begin
                n_sq[g].num = r_sq[g].num - v_t;
                n_sq[g].res = (r_sq[g].res >> 1) + v_bit;
            end else begin
                n_sq[g].res = r_sq[g].res >> 1;
            end
        end
    end

    // divide setup: dividend is magnitude scaled by one
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_dv0.rem[i] = DW'(r_sq[NSQ].m[i]) << FRAC_BITS;
        end
        n_dv0.q    = '0;
        n_dv0.root = r_sq[NSQ].res[MW:0];
        n_dv0.neg  = r_sq[NSQ].neg;
        n_dv0.side = r_sq[NSQ].side;
    end

    // one quotient bit per stage for all three components
    always_comb begin
        logic [DW-1:0] v_d;
        for (int g = 0; g < NDV; g++) begin
            n_dv[g] = r_dv[g];
            v_d     = DW'(r_dv[g].root) << (FRAC_BITS - g);
            for (int i = 0; i < 3; i++) begin
                if (r_dv[g].rem[i] >= v_d) begin
                    n_dv[g].rem[i] = r_dv[g].rem[i] - v_d;
                    n_dv[g].q[i]   = r_dv[g].q[i] | (QW'(1) << (FRAC_BITS - g));
                end
            end
        end
    end

    // sign restore; zero root leaves the vector at zero
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv[NDV].root == '0) begin
                n_o_vec[i] = '0;
            end else if (r_dv[NDV].neg[i]) begin
                n_o_vec[i] = ~OW'(r_dv[NDV].q[i]) + OW'(1);
            end else begin
                n_o_vec[i] = OW'(r_dv[NDV].q[i]);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v  <= 1'b0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r_o_v <= 1'b0;
            for (int g = 0; g <= NSQ; g++) begin
                r_sqv[g] <= 1'b0;
            end
            for (int g = 0; g <= NDV; g++) begin
                r_dvv[g] <= 1'b0;
            end
        end else if (i_en) begin
            r0_v     <= i_valid;
            r1_v     <= r0_v;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r_sqv[0] <= r3_v;
            for (int g = 0; g < NSQ; g++) begin
                r_sqv[g+1] <= r_sqv[g];
            end
            r_dvv[0] <= r_sqv[NSQ];
            for (int g = 0; g < NDV; g++) begin
                r_dvv[g+1] <= r_dvv[g];
            end
            r_o_v <= r_dvv[NDV];
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_mag   <= n0_mag;
            r0_neg   <= n0_neg;
            r0_side  <= i_side;
            r1_mag   <= r0_mag;
            r1_neg   <= r0_neg;
            r1_sh    <= w_sh;
            r1_side  <= r0_side;
            r2_m     <= n2_m;
            r2_neg   <= r1_neg;
            r2_side  <= r1_side;
            r3_sq    <= n3_sq;
            r3_m     <= r2_m;
            r3_neg   <= r2_neg;
            r3_side  <= r2_side;
            r_sq[0]  <= n_sq0;
            for (int g = 0; g < NSQ; g++) begin
                r_sq[g+1] <= n_sq[g];
            end
            r_dv[0] <= n_dv0;
            for (int g = 0; g < NDV; g++) begin
                r_dv[g+1] <= n_dv[g];
            end
            r_o_vec  <= n_o_vec;
            r_o_side <= r_dv[NDV].side;
        end
    end

    assign o_valid = r_o_v;
    assign o_vec   = r_o_vec;
    assign o_side  = r_o_side;

endmodule

// ===== tb/look_at_view_matrix_checker.sv =====
// Watches both channels, predicts the view matrix rows and compares them
module look_at_view_matrix_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  lav_pkg::t_lav_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  lav_pkg::t_lav_out i_out_data,
    output int                o_errors,
    output int                o_pending
);
    import lav_pkg::*;

    t_lav_out rows_due[$];

    assign o_pending = rows_due.size();

    // floor(v / 2^FRAC_BITS)
    function automatic longint floor_shift(longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned num);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > num) bit_v >>= 2;
        while (bit_v != 0) begin
            if (num >= res + bit_v) begin
                num -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // Scale to unit length; zero vector stays zero
    function automatic void unit_vec(input longint v[3], output longint o[3]);
        longint unsigned m[3], mx, sum, r, q;
        int sh;
        mx = 0;
        sum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? 64'd0 - longint'(v[i]) : v[i];
            if (m[i] > mx) mx = m[i];
        end
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        for (int i = 0; i < 3; i++) begin
            m[i] >>= sh;
            sum += m[i] * m[i];
        end
        r = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            if (r == 0) begin
                o[i] = 0;
            end else begin
                q = (m[i] << FRAC_BITS) / r;
                o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
        end
    endfunction

    function automatic void cross_vec(input longint a[3], input longint b[3],
                                      output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Queue the four rows of one item
    task automatic predict_rows(input t_lav_in it);
        longint eye[3], dir[3], upv[3], gaze[3], raw[3], side[3], upa[3];
        longint axis[3], dot;
        t_lav_out r;
        eye = '{longint'(it.eye_x), longint'(it.eye_y), longint'(it.eye_z)};
        upv = '{longint'(it.up_x), longint'(it.up_y), longint'(it.up_z)};
        dir = '{longint'(it.target_x) - eye[0], longint'(it.target_y) - eye[1],
                longint'(it.target_z) - eye[2]};
        unit_vec(dir, gaze);
        cross_vec(upv, gaze, raw);
        unit_vec(raw, side);
        cross_vec(gaze, side, raw);
        for (int i = 0; i < 3; i++) upa[i] = floor_shift(raw[i]);
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (k == 0) axis[i] = side[i];
                else if (k == 1) axis[i] = upa[i];
                else axis[i] = gaze[i];
            end
            dot = 0;
            for (int i = 0; i < 3; i++) dot += clamp32(axis[i]) * eye[i];
            r.row_index = k == 0 ? ROW_SIDE : (k == 1 ? ROW_UP : ROW_GAZE);
            r.col0 = XW'(clamp32(axis[0]));
            r.col1 = XW'(clamp32(axis[1]));
            r.col2 = XW'(clamp32(axis[2]));
            r.col3 = XW'(clamp32(-floor_shift(dot)));
            r.last_row = 1'b0;
            rows_due.push_back(r);
        end
        r.row_index = ROW_CONST;
        r.col0 = '0;
        r.col1 = '0;
        r.col2 = '0;
        r.col3 = XW'(64'd1 << FRAC_BITS);
        r.last_row = 1'b1;
        rows_due.push_back(r);
    endtask

    // Compare each row with the oldest expectation
    always @(posedge i_clk) begin
        t_lav_out e;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) predict_rows(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (rows_due.size() == 0) begin
                    $error("row with nothing expected: row_index %0d",
                           i_out_data.row_index);
                    o_errors <= o_errors + 1;
                end else begin
                    e = rows_due.pop_front();
                    if (e != i_out_data) o_errors <= o_errors + 1;
                    if (e.row_index != i_out_data.row_index)
                        $error("row_index exp %0d got %0d", e.row_index,
                               i_out_data.row_index);
                    if (e.col0 != i_out_data.col0)
                        $error("col0 exp %0d got %0d", e.col0, i_out_data.col0);
                    if (e.col1 != i_out_data.col1)
                        $error("col1 exp %0d got %0d", e.col1, i_out_data.col1);
                    if (e.col2 != i_out_data.col2)
                        $error("col2 exp %0d got %0d", e.col2, i_out_data.col2);
                    if (e.col3 != i_out_data.col3)
                        $error("col3 exp %0d got %0d", e.col3, i_out_data.col3);
                    if (e.last_row != i_out_data.last_row)
                        $error("last_row exp %0d got %0d", e.last_row,
                               i_out_data.last_row);
                end
            end
        end
    end

endmodule

// ===== tb/look_at_view_matrix_unit_test.sv =====
module look_at_view_matrix_unit_test;
    import lav_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int LATENCY    = 2 * FRAC_BITS + 86;
    localparam int CYCLE_CAP  = 200000;
    localparam int N_RANDOM   = 250;
    localparam int QUIET_FROM = 80;
    localparam int QUIET_TO   = 150;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles;
    int   sent;
    bit   quiet;

    lav_in_if  item_ch ();
    lav_out_if row_ch ();

    look_at_view_matrix_unit #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_row   (row_ch.source)
    );

    look_at_view_matrix_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (item_ch.valid),
        .i_in_ready  (item_ch.ready),
        .i_in_data   (item_ch.payload),
        .i_out_valid (row_ch.valid),
        .i_out_ready (row_ch.ready),
        .i_out_data  (row_ch.payload),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stalls with a chance of about 18 in 100, none in the quiet stretch
    always @(negedge i_clk) begin
        row_ch.ready <= quiet || $urandom_range(99) >= 18;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
        endcase
    endfunction

    // Offer one item, hold it until taken; valid stays up for the next one
    task automatic send_item(input t_lav_in it);
        while (!quiet && $urandom_range(99) < 18) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic t_lav_in mk(input logic [31:0] ex, ey, ez, tx, ty, tz,
                                   ux, uy, uz);
        t_lav_in it;
        it = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
        return it;
    endfunction

    initial begin
        t_lav_in it;
        logic [31:0] one;
        one = 32'h0001_0000;
        cycles = 0;
        sent = 0;
        quiet = 0;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        row_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: plain view, zero gaze, up parallel to gaze, extremes
        send_item(mk(0, 0, 0, 0, 0, one, 0, one, 0));
        send_item(mk(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0));
        send_item(mk(0, 0, 0, 0, 0, 5 * one, 0, 0, one));
        send_item(mk(0, 0, 0, one, 0, 0, 0, 0, 0));
        send_item(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_item(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     0, 0, 0, 32'hffff_ffff, 1, 32'hffff_ffff));
        send_item(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
                     32'h7fff_ffff, 0, 0));
        send_item(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_item(mk(32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f,
                     32'hf0f0_f0f0, 32'h5555_5555, 32'haaaa_aaaa,
                     32'hffff_ffff, 32'h0000_0001, 32'h8000_0001));
        item_ch.valid <= 1'b0;

        // Hold off until every row is back
        while (pending != 0) @(negedge i_clk);

        // Random items
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = n >= QUIET_FROM && n < QUIET_TO;
            for (int f = 0; f < 9; f++) it[f*32 +: 32] = rand_coord();
            if ($urandom_range(9) == 0) begin
                it.target_x = it.eye_x;
                it.target_y = it.eye_y;
                it.target_z = it.eye_z;
            end
            send_item(it);
        end
        item_ch.valid <= 1'b0;
        quiet = 0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
